/* rtl/itrc_pkg.sv */
// ----------------------------------------------------------------------------
// itrc_pkg
// Shared types and constants for the periodic interval timer with repeat count.
// ----------------------------------------------------------------------------
package itrc_pkg;

    localparam int unsigned FUNC_W     = 3;
    localparam int unsigned ELAPSED_W  = 32;
    localparam int unsigned TIMEOUT_W  = 64;
    localparam int unsigned REPEAT_W   = 32;
    localparam int unsigned ACC_W      = 64;
    localparam int unsigned INTERVAL_W = 63;

    // Command codes
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SET   = 3'd3;

    // Status codes
    localparam logic STATUS_SUCCESS = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // Fire limit that disables counting
    localparam logic [REPEAT_W-1:0] FIRE_UNLIMITED = '1;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [ELAPSED_W-1:0] elapsed_ns;
        logic [TIMEOUT_W-1:0] period_ns;
        logic [REPEAT_W-1:0]  repeat_limit;
    } cmd_item_t;

    typedef struct packed {
        logic fired;
        logic status;
        logic is_running;
    } rsp_item_t;

endpackage

/* rtl/itrc_in_stage.sv */
// ----------------------------------------------------------------------------
// itrc_in_stage
// Input register: captures one command item and holds it until the timer
// takes it.
// ----------------------------------------------------------------------------
module itrc_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  itrc_pkg::cmd_item_t cmd_item,
    input  logic                advance,
    output logic                item_valid,
    output itrc_pkg::cmd_item_t item
);

    logic                valid_reg;
    logic                valid_next;
    itrc_pkg::cmd_item_t item_reg;

    // Stall while a held item cannot move on
    assign cmd_stall  = valid_reg && !advance;
    assign valid_next = cmd_stall ? valid_reg : cmd_valid;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload when the register is free
    always_ff @(posedge clk)
    begin
        if (!cmd_stall && cmd_valid)
        begin
            item_reg <= cmd_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/itrc_core.sv */
// ----------------------------------------------------------------------------
// itrc_core
// Tick arithmetic: saturating add of the elapsed time, interval compare and
// subtract, and the saturating fire count increment.
// ----------------------------------------------------------------------------
module itrc_core (
    input  logic [itrc_pkg::ACC_W-1:0]      acc,
    input  logic [itrc_pkg::ELAPSED_W-1:0]  elapsed_ns,
    input  logic [itrc_pkg::INTERVAL_W-1:0] interval,
    input  logic [itrc_pkg::REPEAT_W-1:0]   count,
    output logic [itrc_pkg::ACC_W-1:0]      acc_tick,
    output logic                            hit,
    output logic [itrc_pkg::REPEAT_W-1:0]   count_inc
);

    logic [itrc_pkg::ACC_W:0]   sum_wide;
    logic [itrc_pkg::ACC_W-1:0] sum_sat;
    logic [itrc_pkg::ACC_W:0]   diff_wide;

    // Saturating add, then compare and subtract through one borrow chain
    always_comb
    begin
        sum_wide  = {1'b0, acc} + {{(itrc_pkg::ACC_W + 1 - itrc_pkg::ELAPSED_W){1'b0}},
                                   elapsed_ns};
        sum_sat   = sum_wide[itrc_pkg::ACC_W] ? '1 : sum_wide[itrc_pkg::ACC_W-1:0];
        diff_wide = {1'b0, sum_sat} - {{(itrc_pkg::ACC_W + 1 - itrc_pkg::INTERVAL_W){1'b0}},
                                       interval};
        hit       = !diff_wide[itrc_pkg::ACC_W];
        acc_tick  = hit ? diff_wide[itrc_pkg::ACC_W-1:0] : sum_sat;
        count_inc = (count == '1) ? count : count + 1'b1;
    end

endmodule

/* rtl/itrc_timer.sv */
// ----------------------------------------------------------------------------
// itrc_timer
// Timer state and command execution; writes one result item per command
// into the result register.
// ----------------------------------------------------------------------------
module itrc_timer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  advance,
    input  itrc_pkg::cmd_item_t   item,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output itrc_pkg::rsp_item_t   rsp_item
);

    logic                                running_reg;
    logic                                running_next;
    logic [itrc_pkg::ACC_W-1:0]          acc_reg;
    logic [itrc_pkg::ACC_W-1:0]          acc_next;
    logic [itrc_pkg::INTERVAL_W-1:0]     interval_reg;
    logic [itrc_pkg::INTERVAL_W-1:0]     interval_next;
    logic [itrc_pkg::REPEAT_W-1:0]       limit_reg;
    logic [itrc_pkg::REPEAT_W-1:0]       limit_next;
    logic [itrc_pkg::REPEAT_W-1:0]       count_reg;
    logic [itrc_pkg::REPEAT_W-1:0]       count_next;
    logic                                rsp_valid_reg;
    logic                                rsp_valid_next;
    itrc_pkg::rsp_item_t                 rsp_reg;
    itrc_pkg::rsp_item_t                 rsp_next;

    logic                                take;
    logic [itrc_pkg::ACC_W-1:0]          acc_tick;
    logic                                hit;
    logic [itrc_pkg::REPEAT_W-1:0]       count_inc;

    // Move on when the result register is empty or being drained
    assign advance = !rsp_valid_reg || !rsp_stall;
    assign take    = item_valid && advance;

    // Tick arithmetic
    itrc_core u_core (
        .acc        (acc_reg),
        .elapsed_ns (item.elapsed_ns),
        .interval   (interval_reg),
        .count      (count_reg),
        .acc_tick   (acc_tick),
        .hit        (hit),
        .count_inc  (count_inc)
    );

    // Execute the command against the timer state
    always_comb
    begin
        running_next  = running_reg;
        acc_next      = acc_reg;
        interval_next = interval_reg;
        limit_next    = limit_reg;
        count_next    = count_reg;
        rsp_next      = rsp_reg;

        if (take)
        begin
            rsp_next.fired  = 1'b0;
            rsp_next.status = itrc_pkg::STATUS_SUCCESS;
            case (item.func)
                itrc_pkg::FUNC_TICK:
                begin
                    if (running_reg)
                    begin
                        acc_next       = acc_tick;
                        rsp_next.fired = hit;
                        if (hit && (limit_reg != itrc_pkg::FIRE_UNLIMITED))
                        begin
                            count_next = count_inc;
                            if (count_inc >= limit_reg)
                            begin
                                running_next = 1'b0;
                            end
                        end
                    end
                end
                itrc_pkg::FUNC_START:
                begin
                    running_next = 1'b1;
                end
                itrc_pkg::FUNC_STOP:
                begin
                    running_next = 1'b0;
                end
                itrc_pkg::FUNC_SET:
                begin
                    acc_next      = '0;
                    interval_next = item.period_ns[itrc_pkg::INTERVAL_W-1:0];
                    limit_next    = item.repeat_limit;
                    count_next    = '0;
                end
                default:
                begin
                    rsp_next.status = itrc_pkg::STATUS_INVALID;
                end
            endcase
            rsp_next.is_running = running_next;
        end
    end

    // Hold the result until the receiver takes it
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Timer state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            acc_reg       <= '0;
            interval_reg  <= '0;
            limit_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            running_reg   <= running_next;
            acc_reg       <= acc_next;
            interval_reg  <= interval_next;
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

endmodule

/* rtl/interval_timer_repeat_count.sv */
// ----------------------------------------------------------------------------
// interval_timer_repeat_count
// Periodic interval timer with repeat count, one command item in, one result
// item out.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel: cmd_valid / cmd_stall / cmd_item carry commands (tick,
//   start, stop, set). rsp channel: rsp_valid / rsp_stall / rsp_item carry
//   one result (fired, status, is_running) per command, in order.
//   Order: an accepted command moves from the input register into the
//   result register once that one is empty or being drained. Throughput:
//   one command per cycle while rsp_stall is low. The timer state is read
//   and written by one pass of add, compare and subtract in the result
//   stage, so each command sees the state left by the one before it with
//   no wait.
//   Reset: running flag, accumulator, interval, fire limit and fire count
//   clear to zero; both pipeline registers empty.
//   Receiver stall: the result register holds its item; a further command
//   waits in the input register, and only then is cmd_stall raised.
// ----------------------------------------------------------------------------
module interval_timer_repeat_count (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  itrc_pkg::cmd_item_t cmd_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output itrc_pkg::rsp_item_t rsp_item
);

    itrc_pkg::cmd_item_t   item;
    logic                  item_valid;
    logic                  advance;

    // Input register
    itrc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_item   (cmd_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Timer state and result register
    itrc_timer u_timer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .advance    (advance),
        .item       (item),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_item   (rsp_item)
    );

endmodule

/* verif/tb_interval_timer_repeat_count.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_timer_repeat_count
// Self-checking bench for the periodic interval timer with repeat count.
// Commands go in through the valid/stall channel and a local timer model
// predicts each result. Every result is checked against the oldest
// prediction. Directed cases come first, then random command sequences under
// three mixes of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_interval_timer_repeat_count;

    // Codes that the block answers with the invalid status
    localparam logic [itrc_pkg::FUNC_W-1:0] FUNC_FIRST_INVALID = 3'd4;
    localparam logic [itrc_pkg::FUNC_W-1:0] FUNC_LAST_INVALID  = 3'd7;

    localparam int unsigned TICK_SPAN_MAX = 3000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    itrc_pkg::cmd_item_t cmd_item = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    itrc_pkg::rsp_item_t rsp_item;

    // Timer model state
    logic                            tmr_running;
    logic [itrc_pkg::ACC_W-1:0]      tmr_acc;
    logic [itrc_pkg::INTERVAL_W-1:0] tmr_interval;
    logic [itrc_pkg::REPEAT_W-1:0]   tmr_limit;
    logic [itrc_pkg::REPEAT_W-1:0]   tmr_fires;

    itrc_pkg::rsp_item_t timer_rsp_q[$];

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int err_count = 0;
    int cmd_count = 0;
    int fire_count = 0;
    int rsp_count = 0;

    interval_timer_repeat_count u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    // Generate the 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one command to the timer model and return its result
    function automatic itrc_pkg::rsp_item_t timer_apply_cmd(itrc_pkg::cmd_item_t c);
        itrc_pkg::rsp_item_t      r;
        logic [itrc_pkg::ACC_W:0] sum;
        r = '0;
        r.status = itrc_pkg::STATUS_SUCCESS;
        case (c.func)
            itrc_pkg::FUNC_TICK:
            begin
                if (tmr_running)
                begin
                    // Saturate the accumulator on overflow
                    sum = {1'b0, tmr_acc}
                        + {{(itrc_pkg::ACC_W - itrc_pkg::ELAPSED_W + 1){1'b0}},
                           c.elapsed_ns};
                    tmr_acc = sum[itrc_pkg::ACC_W] ? '1 : sum[itrc_pkg::ACC_W-1:0];
                    if (tmr_acc >= {1'b0, tmr_interval})
                    begin
                        r.fired = 1'b1;
                        tmr_acc = tmr_acc - {1'b0, tmr_interval};
                        if (tmr_limit != itrc_pkg::FIRE_UNLIMITED)
                        begin
                            if (tmr_fires != '1)
                                tmr_fires = tmr_fires + 1'b1;
                            if (tmr_fires >= tmr_limit)
                                tmr_running = 1'b0;
                        end
                    end
                end
            end
            itrc_pkg::FUNC_START: tmr_running = 1'b1;
            itrc_pkg::FUNC_STOP:  tmr_running = 1'b0;
            itrc_pkg::FUNC_SET:
            begin
                tmr_acc      = '0;
                tmr_interval = c.period_ns[itrc_pkg::INTERVAL_W-1:0];
                tmr_limit    = c.repeat_limit;
                tmr_fires    = '0;
            end
            default: r.status = itrc_pkg::STATUS_INVALID;
        endcase
        r.is_running = tmr_running;
        return r;
    endfunction

    // Fill every field of a command with random bits
    function automatic itrc_pkg::cmd_item_t random_cmd();
        itrc_pkg::cmd_item_t c;
        c.func         = itrc_pkg::FUNC_W'($urandom_range(0, 7));
        c.elapsed_ns   = $urandom;
        c.period_ns    = {$urandom, $urandom};
        c.repeat_limit = $urandom;
        return c;
    endfunction

    // Send one item, predicting its result at the accepting edge
    task automatic send_cmd(itrc_pkg::cmd_item_t c);
        // Idle the sender at random before it offers the item
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_item  <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        timer_rsp_q.push_back(timer_apply_cmd(c));
        cmd_count++;
    endtask

    // Send a command with the given fields; unused fields carry noise
    task automatic issue(logic [itrc_pkg::FUNC_W-1:0] func,
                         logic [itrc_pkg::ELAPSED_W-1:0] elapsed,
                         logic [itrc_pkg::TIMEOUT_W-1:0] period,
                         logic [itrc_pkg::REPEAT_W-1:0] rpt);
        itrc_pkg::cmd_item_t c;
        c = random_cmd();
        c.func = func;
        if (func == itrc_pkg::FUNC_TICK)
            c.elapsed_ns = elapsed;
        if (func == itrc_pkg::FUNC_SET)
        begin
            c.period_ns    = period;
            c.repeat_limit = rpt;
        end
        send_cmd(c);
    endtask

    // Hold the sender off until every result is back
    task automatic hold_until_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (timer_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // Drive the receiver stall
    always @(negedge clk)
        rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);

    // Check each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        itrc_pkg::rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (timer_rsp_q.size() == 0)
            begin
                $error("result item with no command pending");
                err_count++;
            end
            else
            begin
                want = timer_rsp_q.pop_front();
                rsp_count++;
                if (want.fired)
                    fire_count++;
                if (rsp_item.fired !== want.fired)
                begin
                    $error("fired: expected %0b, actual %0b", want.fired, rsp_item.fired);
                    err_count++;
                end
                if (rsp_item.status !== want.status)
                begin
                    $error("status: expected %0b, actual %0b", want.status, rsp_item.status);
                    err_count++;
                end
                if (rsp_item.is_running !== want.is_running)
                begin
                    $error("is_running: expected %0b, actual %0b",
                           want.is_running, rsp_item.is_running);
                    err_count++;
                end
            end
        end
    end

    // Tick while stopped, unknown codes, widest fields
    task automatic test_idle_and_extremes();
        issue(itrc_pkg::FUNC_TICK, '1, '0, '0);
        for (int f = FUNC_FIRST_INVALID; f <= FUNC_LAST_INVALID; f++)
            issue(itrc_pkg::FUNC_W'(f), '1, '1, '1);
        issue(itrc_pkg::FUNC_SET, '0, '1, itrc_pkg::FIRE_UNLIMITED);
        issue(itrc_pkg::FUNC_START, '0, '0, '0);
        issue(itrc_pkg::FUNC_TICK, '1, '0, '0);
    endtask

    // Zero interval: every running tick fires
    task automatic test_zero_interval();
        issue(itrc_pkg::FUNC_SET, '0, '0, itrc_pkg::FIRE_UNLIMITED);
        issue(itrc_pkg::FUNC_START, '0, '0, '0);
        issue(itrc_pkg::FUNC_TICK, '0, '0, '0);
        issue(itrc_pkg::FUNC_TICK, 32'd77, '0, '0);
    endtask

    // Zero fire limit: the first fire stops the timer
    task automatic test_zero_limit();
        issue(itrc_pkg::FUNC_SET, '0, 64'd100, '0);
        issue(itrc_pkg::FUNC_START, '0, '0, '0);
        issue(itrc_pkg::FUNC_TICK, 32'd150, '0, '0);
        issue(itrc_pkg::FUNC_TICK, 32'd150, '0, '0);
    endtask

    // Restart after the limit was reached: keeps counting past the limit
    task automatic test_restart_after_limit();
        issue(itrc_pkg::FUNC_SET, '0, 64'd50, 32'd1);
        issue(itrc_pkg::FUNC_START, '0, '0, '0);
        issue(itrc_pkg::FUNC_TICK, 32'd60, '0, '0);
        issue(itrc_pkg::FUNC_START, '0, '0, '0);
        issue(itrc_pkg::FUNC_TICK, 32'd40, '0, '0);
    endtask

    // Start keeps the accumulator; bit 63 of the interval is dropped
    task automatic test_start_keeps_progress();
        issue(itrc_pkg::FUNC_SET, '0, 64'h8000_0000_0000_03E8, itrc_pkg::FIRE_UNLIMITED);
        issue(itrc_pkg::FUNC_START, '0, '0, '0);
        issue(itrc_pkg::FUNC_TICK, 32'd600, '0, '0);
        issue(itrc_pkg::FUNC_STOP, '0, '0, '0);
        issue(itrc_pkg::FUNC_START, '0, '0, '0);
        issue(itrc_pkg::FUNC_TICK, 32'd600, '0, '0);
    endtask

    // Pause the sender mid-sequence until everything has drained
    task automatic test_pause_until_drained();
        issue(itrc_pkg::FUNC_SET, '0, 64'd10, 32'd3);
        issue(itrc_pkg::FUNC_START, '0, '0, '0);
        issue(itrc_pkg::FUNC_TICK, 32'd12, '0, '0);
        hold_until_drained();
        issue(itrc_pkg::FUNC_TICK, 32'd9, '0, '0);
        issue(itrc_pkg::FUNC_TICK, 32'd30, '0, '0);
    endtask

    // Random set/start/tick sequences with noise and broken sequences
    task automatic test_random_traffic(int n_items);
        itrc_pkg::cmd_item_t            c;
        int                             sent;
        int                             burst;
        int unsigned                    span;
        logic [itrc_pkg::REPEAT_W-1:0]  rpt;
        logic [itrc_pkg::TIMEOUT_W-1:0] tmo;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                // Pick the interval: mostly small so fires happen
                case ($urandom_range(0, 9))
                    0:       tmo = {$urandom, $urandom};
                    1:       tmo = {1'($urandom_range(0, 1)), 63'd0};
                    default: tmo = {1'($urandom_range(0, 1)), 31'd0,
                                    32'($urandom_range(1, TICK_SPAN_MAX))};
                endcase
                case ($urandom_range(0, 9))
                    0:       rpt = itrc_pkg::FIRE_UNLIMITED;
                    1:       rpt = $urandom;
                    default: rpt = $urandom_range(0, 6);
                endcase
                issue(itrc_pkg::FUNC_SET, '0, tmo, rpt);
                if ($urandom_range(0, 9) != 0)
                    issue(itrc_pkg::FUNC_START, '0, '0, '0);
                sent += 2;
                span = (tmo[itrc_pkg::INTERVAL_W-1:0] < TICK_SPAN_MAX) ?
                       tmo[31:0] : TICK_SPAN_MAX;
                burst = $urandom_range(4, 30);
                repeat (burst)
                begin
                    c = random_cmd();
                    if ($urandom_range(0, 9) != 0)
                        c.func = itrc_pkg::FUNC_TICK;
                    case ($urandom_range(0, 9))
                        0:       c.elapsed_ns = $urandom;
                        1:       c.elapsed_ns = '0;
                        default: c.elapsed_ns = $urandom_range(0, 2 * span + 1);
                    endcase
                    send_cmd(c);
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                begin
                    send_cmd(random_cmd());
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        tmr_running  = 1'b0;
        tmr_acc      = '0;
        tmr_interval = '0;
        tmr_limit    = '0;
        tmr_fires    = '0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        snd_idle_pct = 25;
        rcv_idle_pct = 64;
        test_idle_and_extremes();
        test_zero_interval();
        test_zero_limit();
        test_restart_after_limit();
        test_start_keeps_progress();
        test_pause_until_drained();
        test_random_traffic(400);

        snd_idle_pct = 64;
        rcv_idle_pct = 25;
        test_random_traffic(400);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_traffic(400);

        // Drain and let the pipeline settle
        hold_until_drained();
        repeat (8) @(posedge clk);
        if (timer_rsp_q.size() != 0)
        begin
            $error("%0d results never arrived", timer_rsp_q.size());
            err_count++;
        end

        $display("Sent %0d commands and checked %0d results, %0d of them fires,",
                 cmd_count, rsp_count, fire_count);
        $display("over directed timer cases and three sender/receiver idle mixes.");
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
